### rtl/ale_pkg.sv
`default_nettype none

package ale_pkg;

  localparam int WordW  = 32;
  localparam int IndexW = 6;
  localparam int CountW = 7;

  typedef enum logic [2:0] {
    MODE_GET    = 3'd0,
    MODE_SET    = 3'd1,
    MODE_APPEND = 3'd2,
    MODE_DROP   = 3'd3,
    MODE_INSERT = 3'd4,
    MODE_REMOVE = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Command broadcast to every entry cell in the cycle an item is accepted
  typedef struct packed {
    logic                     write;
    logic [CountW-1:0]        write_pos;
    logic                     shift_up;
    logic                     shift_down;
    logic [IndexW-1:0]        index;
    logic signed [WordW-1:0]  value;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/ale_req_if.sv
`default_nettype none

interface ale_req_if;
  import ale_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [2:0]              mode;
  logic [IndexW-1:0]       index;
  logic signed [WordW-1:0] value;

  modport source (output valid, mode, index, value, input ready);
  modport sink (input valid, mode, index, value, output ready);
endinterface

interface ale_rsp_if;
  import ale_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] read_value;
  logic [1:0]              status;
  logic [CountW-1:0]       count;

  modport source (output valid, read_value, status, count, input ready);
  modport sink (input valid, read_value, status, count, output ready);
endinterface

`default_nettype wire

### rtl/array_list_engine.sv
// Channel  Dir  Payload                          Accepted when
// -------  ---  -------------------------------  ---------------------
// req      in   mode[2:0] index[5:0] value[31:0]  req.valid & req.ready
// rsp      out  read_value[31:0] status[1:0]     rsp.valid & rsp.ready
//               count[6:0]
// cfg      in   cfg_data[6:0] (capacity)         cfg_we
//
// One item per cycle while results are taken: the entry cells an item
// changes update in the cycle it is accepted, and the result is held in a
// single output register. The read path is a one-hot select over DEPTH
// cells into that register. Reset clears the count, the output valid and
// sets capacity to 64; entry contents are not cleared. A stalled result
// blocks new items only while it is still waiting to be taken.
`default_nettype none

module array_list_engine #(
  parameter int DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ale_pkg::CountW-1:0]    cfg_data,
  ale_req_if.sink                            req,
  ale_rsp_if.source                          rsp
);
  import ale_pkg::*;

  // Capacity is bounded by the cell count and by the count field's range
  localparam int CapLimit = (DEPTH > 127) ? 127 : DEPTH;

  logic [CountW-1:0]       capacity;
  logic [CountW-1:0]       count;
  logic [CountW-1:0]       count_next;
  logic [CountW-1:0]       cap_eff;
  logic                    accept;
  logic                    in_range;
  logic                    full;
  status_t                 status_next;
  logic signed [WordW-1:0] rd_next;
  logic signed [WordW-1:0] rd_sel;
  cmd_t                    cmd;

  logic signed [WordW-1:0] ent   [DEPTH];
  logic signed [WordW-1:0] left  [DEPTH];
  logic signed [WordW-1:0] right [DEPTH];

  logic                    out_valid;
  logic signed [WordW-1:0] out_read;
  status_t                 out_status;
  logic [CountW-1:0]       out_count;

  // Take a new item whenever the output register is free or being drained
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign cap_eff  = (capacity > CountW'(CapLimit)) ? CountW'(CapLimit) : capacity;
  assign full     = count >= cap_eff;
  assign in_range = {1'b0, req.index} < count;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CountW'(64);
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // One-hot select of the addressed entry
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (32'(i) == {{(32-IndexW){1'b0}}, req.index}) begin
        rd_sel = rd_sel | ent[i];
      end
    end
  end

  // Decode the request into a cell command, a status and the new count
  always_comb begin
    cmd            = '0;
    cmd.index      = req.index;
    cmd.value      = req.value;
    cmd.write_pos  = {1'b0, req.index};
    status_next    = ST_OK;
    rd_next        = '0;
    count_next     = count;
    case (mode_t'(req.mode))
      MODE_GET: begin
        if (in_range) rd_next = rd_sel;
        else status_next = ST_BAD_INDEX;
      end
      MODE_SET: begin
        if (in_range) cmd.write = accept;
        else status_next = ST_BAD_INDEX;
      end
      MODE_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.write     = accept;
          cmd.write_pos = count;
          count_next    = count + 1'b1;
        end
      end
      MODE_DROP: begin
        if (count == '0) status_next = ST_EMPTY;
        else count_next = count - 1'b1;
      end
      MODE_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (!in_range) begin
          status_next = ST_BAD_INDEX;
        end else begin
          cmd.write    = accept;
          cmd.shift_up = accept;
          count_next   = count + 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (!in_range) begin
          status_next = ST_BAD_INDEX;
        end else begin
          cmd.shift_down = accept;
          count_next     = count - 1'b1;
        end
      end
      default: begin
        // unused modes leave everything as it is
      end
    endcase
  end

  // Row of entry cells; the ends see their own word as the missing neighbour
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left[g] = ent[g];
    end else begin : g_mid_l
      assign left[g] = ent[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right[g] = ent[g];
    end else begin : g_mid_r
      assign right[g] = ent[g+1];
    end

    ale_cell #(
      .POS (g)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .left  (left[g]),
      .right (right[g]),
      .data  (ent[g])
    );
  end

  // Count and output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      out_read   <= rd_next;
      out_status <= status_next;
      out_count  <= count_next;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_read;
  assign rsp.status     = out_status;
  assign rsp.count      = out_count;

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    {{(32-CountW){1'b0}}, count} <= 32'(DEPTH))
    else $error("entry count beyond cell row");

  a_count_shown : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_count == count)
    else $error("result count differs from held count");

  a_read_ok : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_read != '0) |-> out_status == ST_OK)
    else $error("read data on a refused item");

  a_drop : assert property (@(posedge clk) disable iff (rst)
    (accept && req.mode == MODE_DROP && count != '0) |=> count == $past(count) - 1'b1)
    else $error("drop last did not lower count");

endmodule

`default_nettype wire

### rtl/ale_cell.sv
`default_nettype none

module ale_cell #(
  parameter int POS = 0
) (
  input  wire logic                             clk,
  input  wire ale_pkg::cmd_t                    cmd,
  input  wire logic signed [ale_pkg::WordW-1:0] left,
  input  wire logic signed [ale_pkg::WordW-1:0] right,
  output logic signed [ale_pkg::WordW-1:0]      data
);
  import ale_pkg::*;

  localparam logic [31:0] PosW = 32'(POS);

  logic hit_write;
  logic above_index;
  logic at_or_above_index;

  assign hit_write         = cmd.write && (PosW == {{(32-CountW){1'b0}}, cmd.write_pos});
  assign above_index       = PosW > {{(32-IndexW){1'b0}}, cmd.index};
  assign at_or_above_index = PosW >= {{(32-IndexW){1'b0}}, cmd.index};

  // Write wins at the target; insert takes from the left, remove from the right
  always_ff @(posedge clk) begin
    if (hit_write) begin
      data <= cmd.value;
    end else if (cmd.shift_up && above_index) begin
      data <= left;
    end else if (cmd.shift_down && at_or_above_index) begin
      data <= right;
    end
  end

endmodule

`default_nettype wire
